// File: hdl/ctd_pkg.sv
package ctd_pkg;

  localparam int unsigned KindW = 2;
  localparam int unsigned ErrW  = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgW  = 4;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE  = 2'd0,
    ERR_LONG  = 2'd1,
    ERR_CHAR  = 2'd2,
    ERR_DELIM = 2'd3
  } err_e;

  localparam logic [ByteW-1:0] ChCr = 8'h0D;
  localparam logic [ByteW-1:0] ChLf = 8'h0A;

  localparam logic [CfgW-1:0] DigitsReset = 4'd6;
  localparam logic [CfgW-1:0] DigitsMin   = 4'd1;
  localparam logic [CfgW-1:0] DigitsMax   = 4'd8;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data;
    logic              last;
    err_e              err;
  } result_t;

endpackage

// File: hdl/chunked_transfer_decoder_unit.sv
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_valid_i / cfg_ready_o max_size_digits_i
// in        in         in_valid_i / in_ready_o   rx_byte_i
// out       out        out_valid_o / out_ready_i result_kind_o, payload_byte_o,
//                                                chunk_last_o, error_code_o
//
// One byte is taken per cycle while in_ready_o is high; its result, if any,
// enters a two-entry result buffer behind the parser and is shown once any
// older results are taken; in_ready_o drops whenever both entries are full.
// Reset clears the parser to the size line and sets max_size_digits to 6.
// After an end of stream or an error, bytes are taken and dropped until reset.
module chunked_transfer_decoder_unit #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ctd_pkg::CfgW-1:0]   max_size_digits_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ctd_pkg::ByteW-1:0]  rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ctd_pkg::KindW-1:0]  result_kind_o,
  output logic [ctd_pkg::ByteW-1:0]  payload_byte_o,
  output logic                       chunk_last_o,
  output logic [ctd_pkg::ErrW-1:0]   error_code_o
);
  import ctd_pkg::*;

  localparam logic [2:0] PhSize = 3'd0;
  localparam logic [2:0] PhData = 3'd1;
  localparam logic [2:0] PhDcr  = 3'd2;
  localparam logic [2:0] PhDlf  = 3'd3;
  localparam logic [2:0] PhEnd  = 3'd4;
  localparam logic [2:0] PhHalt = 3'd5;

  logic [CfgW-1:0]      max_digits_q;
  logic [CfgW-1:0]      limit;
  logic [2:0]           phase_q, phase_d;
  logic [SIZE_BITS-1:0] acc_q, acc_d;
  logic [SIZE_BITS-1:0] rem_q, rem_d;
  logic [SIZE_BITS-1:0] acc_shift, rem_dec;
  logic [CfgW-1:0]      dcnt_q, dcnt_d;
  logic                 cr_q, cr_d;
  logic                 is_hex;
  logic [3:0]           hex_val;
  logic                 in_accept;
  logic                 res_valid;
  result_t              res;

  result_t              fifo_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q;
  logic                 push, pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (count_q != 2'd2);
  assign in_accept   = in_valid_i & in_ready_o;

  always_comb begin
    if (max_digits_q < DigitsMin) begin
      limit = DigitsMin;
    end else if (max_digits_q > DigitsMax) begin
      limit = DigitsMax;
    end else begin
      limit = max_digits_q;
    end
  end

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39) begin
      hex_val = rx_byte_i[3:0];
    end else if ((rx_byte_i >= 8'h41 && rx_byte_i <= 8'h46) ||
                 (rx_byte_i >= 8'h61 && rx_byte_i <= 8'h66)) begin
      hex_val = rx_byte_i[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign acc_shift = SIZE_BITS'({acc_q, hex_val});
  assign rem_dec   = rem_q - SIZE_BITS'(1);

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    cr_d      = cr_q;
    res_valid = 1'b0;
    res       = '{kind: KIND_PAYLOAD, data: '0, last: 1'b0, err: ERR_NONE};
    if (in_accept) begin
      unique case (phase_q)
        PhSize: begin
          if (cr_q) begin
            if (rx_byte_i != ChLf) begin
              phase_d   = PhHalt;
              res_valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.err   = ERR_CHAR;
            end else begin
              acc_d  = '0;
              dcnt_d = '0;
              cr_d   = 1'b0;
              if (acc_q == '0) begin
                phase_d   = PhEnd;
                res_valid = 1'b1;
                res.kind  = KIND_END;
              end else begin
                rem_d   = acc_q;
                phase_d = PhData;
              end
            end
          end else if (rx_byte_i == ChCr) begin
            cr_d = 1'b1;
          end else if (!is_hex) begin
            phase_d   = PhHalt;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_CHAR;
          end else if (dcnt_q >= limit) begin
            phase_d   = PhHalt;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_LONG;
          end else begin
            dcnt_d = dcnt_q + 4'd1;
            acc_d  = acc_shift;
          end
        end
        PhData: begin
          rem_d     = rem_dec;
          res_valid = 1'b1;
          res.data  = rx_byte_i;
          if (rem_dec == '0) begin
            phase_d  = PhDcr;
            res.last = 1'b1;
          end
        end
        PhDcr: begin
          if (rx_byte_i != ChCr) begin
            phase_d   = PhHalt;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_DELIM;
          end else begin
            phase_d = PhDlf;
          end
        end
        PhDlf: begin
          if (rx_byte_i != ChLf) begin
            phase_d   = PhHalt;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_DELIM;
          end else begin
            acc_d   = '0;
            dcnt_d  = '0;
            cr_d    = 1'b0;
            phase_d = PhSize;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_digits_q <= DigitsReset;
      phase_q      <= PhSize;
      acc_q        <= '0;
      rem_q        <= '0;
      dcnt_q       <= '0;
      cr_q         <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_digits_q <= max_size_digits_i;
      end
      phase_q <= phase_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      dcnt_q  <= dcnt_d;
      cr_q    <= cr_d;
    end
  end

  assign push = in_accept & res_valid;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign out_valid_o    = (count_q != 2'd0);
  assign result_kind_o  = fifo_q[rd_ptr_q].kind;
  assign payload_byte_o = fifo_q[rd_ptr_q].data;
  assign chunk_last_o   = fifo_q[rd_ptr_q].last;
  assign error_code_o   = fifo_q[rd_ptr_q].err;

endmodule

// File: hdl/ctd_checker.sv
module ctd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [ctd_pkg::KindW-1:0]  result_kind_o,
  input logic                       chunk_last_o,
  input logic [ctd_pkg::ErrW-1:0]   error_code_o
);
  import ctd_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out transaction dropped before acceptance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match result kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chunk_last_o |-> result_kind_o == KIND_PAYLOAD)
    else $error("chunk_last on a non-payload transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i &&
    (result_kind_o == KIND_ERROR || result_kind_o == KIND_END) |=> !out_valid_o)
    else $error("transaction after end of stream or error");

endmodule

bind chunked_transfer_decoder_unit ctd_checker u_ctd_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ctd_pkg::*;

  typedef enum logic [2:0] {
    DP_SIZE,
    DP_DATA,
    DP_CR,
    DP_LF,
    DP_DONE,
    DP_HALT
  } decode_phase_e;

  typedef enum int {
    FIN_ZERO,
    FIN_LONG,
    FIN_CHAR,
    FIN_DELIM,
    FIN_OPEN
  } finish_e;

  typedef enum int {
    RD_OPEN,
    RD_LIGHT,
    RD_HEAVY,
    RD_TOGGLE
  } ready_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  max_size_digits_i = DigitsReset;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] rx_byte_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [KindW-1:0] result_kind_o;
  logic [ByteW-1:0] payload_byte_o;
  logic             chunk_last_o;
  logic [ErrW-1:0]  error_code_o;

  // decoder mirror
  decode_phase_e dec_phase = DP_SIZE;
  logic [31:0]   size_acc = '0;
  logic [3:0]    size_digits = '0;
  logic          size_cr = 1'b0;
  logic [31:0]   data_left = '0;
  logic [3:0]    cfg_digits = DigitsReset;

  logic [ByteW-1:0] body_bytes[$];
  logic [ByteW-1:0] stage_q[$];
  result_t          decoded_q[$];

  int unsigned mismatches = 0;
  bit          in_fire = 1'b0;
  bit          sender_hold = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned hold_off_left = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned pattern_left = 0;
  ready_mode_e ready_mode = RD_OPEN;

  chunked_transfer_decoder_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .max_size_digits_i (max_size_digits_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_kind_o     (result_kind_o),
    .payload_byte_o    (payload_byte_o),
    .chunk_last_o      (chunk_last_o),
    .error_code_o      (error_code_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int digit_of(input logic [ByteW-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic int digit_limit();
    if (cfg_digits < DigitsMin) return int'(DigitsMin);
    if (cfg_digits > DigitsMax) return int'(DigitsMax);
    return int'(cfg_digits);
  endfunction

  function automatic bit raise(input err_e code, output result_t r);
    dec_phase = DP_HALT;
    r = '0;
    r.kind = KIND_ERROR;
    r.err = code;
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [ByteW-1:0] c, output result_t r);
    int d;
    r = '0;
    case (dec_phase)
      DP_SIZE: begin
        if (size_cr) begin
          if (c != ChLf) return raise(ERR_CHAR, r);
          size_cr = 1'b0;
          size_digits = '0;
          if (size_acc == '0) begin
            dec_phase = DP_DONE;
            r.kind = KIND_END;
            return 1'b1;
          end
          data_left = size_acc;
          size_acc = '0;
          dec_phase = DP_DATA;
          return 1'b0;
        end
        if (c == ChCr) begin
          size_cr = 1'b1;
          return 1'b0;
        end
        d = digit_of(c);
        if (d < 0) return raise(ERR_CHAR, r);
        if (int'(size_digits) >= digit_limit()) return raise(ERR_LONG, r);
        size_digits = size_digits + 4'd1;
        size_acc = {size_acc[27:0], d[3:0]};
        return 1'b0;
      end
      DP_DATA: begin
        data_left = data_left - 32'd1;
        r.kind = KIND_PAYLOAD;
        r.data = c;
        r.last = (data_left == '0);
        if (r.last) dec_phase = DP_CR;
        return 1'b1;
      end
      DP_CR: begin
        if (c != ChCr) return raise(ERR_DELIM, r);
        dec_phase = DP_LF;
        return 1'b0;
      end
      DP_LF: begin
        if (c != ChLf) return raise(ERR_DELIM, r);
        size_acc = '0;
        size_digits = '0;
        size_cr = 1'b0;
        dec_phase = DP_SIZE;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(input string field, input logic [ByteW-1:0] got,
                               input logic [ByteW-1:0] want);
    $display("mismatch on %s: got %h, want %h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t fresh;
    if (rst_ni) begin
      in_fire = in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          flag_mismatch("unexpected result kind", result_kind_o, '0);
        end else begin
          want = decoded_q.pop_front();
          if (result_kind_o !== want.kind) flag_mismatch("kind", result_kind_o, want.kind);
          if (payload_byte_o !== want.data) flag_mismatch("byte", payload_byte_o, want.data);
          if (chunk_last_o !== want.last) flag_mismatch("last", chunk_last_o, want.last);
          if (error_code_o !== want.err) flag_mismatch("error", error_code_o, want.err);
        end
      end
      if (in_fire) begin
        if (decode_byte(rx_byte_i, fresh)) decoded_q.push_back(fresh);
      end
    end
  end

  always @(negedge clk_i) begin : sender
    logic             offer;
    logic [ByteW-1:0] next_byte;
    offer = 1'b0;
    next_byte = rx_byte_i;
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (!sender_hold && body_bytes.size() != 0) begin
        offer = 1'b1;
        next_byte = body_bytes.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_valid_i <= offer;
      rx_byte_i <= next_byte;
    end
  end

  always @(negedge clk_i) begin : receiver
    logic take;
    if (hold_off_req) begin
      hold_off_left = 90;
      hold_off_req = 1'b0;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      take = 1'b0;
    end else begin
      if (pattern_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(8, 60);
      end
      pattern_left--;
      case (ready_mode)
        RD_OPEN:  take = 1'b1;
        RD_LIGHT: take = ($urandom_range(0, 3) != 0);
        RD_HEAVY: take = ($urandom_range(0, 3) == 0);
        default:  take = !out_ready_i;
      endcase
    end
    out_ready_i <= take;
  end

  function automatic logic [ByteW-1:0] hex_char(input int nib, input bit upper);
    if (nib < 10) return 8'(8'h30 + nib);
    return 8'((upper ? 8'h41 : 8'h61) + nib - 10);
  endfunction

  function automatic int min_digits(input logic [31:0] value);
    int n;
    n = 1;
    while (n < 8 && (value >> (4 * n)) != 0) n++;
    return n;
  endfunction

  function automatic logic [ByteW-1:0] random_data();
    case ($urandom_range(0, 7))
      0:       return ChCr;
      1:       return ChLf;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_size_line(input logic [31:0] value, input int ndigits);
    for (int i = ndigits - 1; i >= 0; i--) begin
      stage_q.push_back(hex_char(int'((value >> (4 * i)) & 32'hF), $urandom_range(0, 1)));
    end
    stage_q.push_back(ChCr);
    stage_q.push_back(ChLf);
  endtask

  task automatic add_chunk_body(input logic [31:0] size, input int ndigits);
    add_size_line(size, ndigits);
    for (int i = 0; i < int'(size); i++) stage_q.push_back(random_data());
  endtask

  task automatic add_chunks(input int budget);
    int          used;
    int          lim;
    int          nd;
    logic [31:0] size;
    used = 0;
    while (used < budget) begin
      lim = digit_limit();
      if (lim == 1) size = $urandom_range(1, 15);
      else size = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
      nd = $urandom_range(min_digits(size), lim);
      add_chunk_body(size, nd);
      stage_q.push_back(ChCr);
      stage_q.push_back(ChLf);
      used += int'(size) + nd + 4;
    end
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(8, 24);
    repeat (n) stage_q.push_back(random_data());
  endtask

  function automatic logic [ByteW-1:0] foreign_byte();
    logic [ByteW-1:0] b;
    do b = 8'($urandom_range(0, 255)); while (digit_of(b) >= 0 || b == ChCr);
    return b;
  endfunction

  function automatic logic [ByteW-1:0] byte_other_than(input logic [ByteW-1:0] avoid);
    logic [ByteW-1:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  task automatic add_ending();
    finish_e how;
    int      lim;
    int      n;
    how = finish_e'($urandom_range(0, 4));
    lim = digit_limit();
    case (how)
      FIN_ZERO: begin
        n = $urandom_range(0, lim);
        repeat (n) stage_q.push_back(8'h30);
        stage_q.push_back(ChCr);
        stage_q.push_back(ChLf);
        add_noise();
      end
      FIN_LONG: begin
        repeat (lim + 1) stage_q.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
        add_noise();
      end
      FIN_CHAR: begin
        n = $urandom_range(0, lim);
        repeat (n) stage_q.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
        case ($urandom_range(0, 2))
          0: stage_q.push_back(foreign_byte());
          1: stage_q.push_back(ChLf);
          default: begin
            stage_q.push_back(ChCr);
            stage_q.push_back(byte_other_than(ChLf));
          end
        endcase
        add_noise();
      end
      FIN_DELIM: begin
        add_chunk_body($urandom_range(1, 8), 1);
        if ($urandom_range(0, 1) == 0) begin
          stage_q.push_back(byte_other_than(ChCr));
        end else begin
          stage_q.push_back(ChCr);
          stage_q.push_back(byte_other_than(ChLf));
        end
        add_noise();
      end
      default: begin
        // all-F size line; the stream stays open in the data phase
        repeat (lim) stage_q.push_back(hex_char(15, $urandom_range(0, 1)));
        stage_q.push_back(ChCr);
        stage_q.push_back(ChLf);
        n = $urandom_range(5, 12);
        repeat (n) stage_q.push_back(random_data());
      end
    endcase
  endtask

  task automatic launch();
    @(posedge clk_i);
    foreach (stage_q[i]) body_bytes.push_back(stage_q[i]);
    stage_q.delete();
  endtask

  task automatic wait_quiet(input bit all_sent);
    bit idle;
    forever begin
      @(posedge clk_i);
      idle = !in_valid_i && (!all_sent || body_bytes.size() == 0);
      @(negedge clk_i);
      if (idle && decoded_q.size() == 0) break;
    end
  endtask

  task automatic write_digit_limit(input logic [CfgW-1:0] value);
    max_size_digits_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_digits = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] settings[8];
    settings[0] = DigitsMin;
    settings[1] = DigitsMax;
    settings[2] = 4'd0;
    settings[3] = 4'd15;
    settings[4] = 4'($urandom_range(2, 7));
    settings[5] = 4'($urandom_range(0, 15));
    settings[6] = 4'($urandom_range(0, 15));
    settings[7] = 4'($urandom_range(0, 15));
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    add_chunk_body(32'd1, 1);
    stage_q.push_back(ChCr);
    stage_q.push_back(ChLf);
    stage_q[3] = 8'h00;
    add_chunk_body(32'd2, 6);
    stage_q[stage_q.size() - 2] = 8'hFF;
    stage_q[stage_q.size() - 1] = ChCr;
    stage_q.push_back(ChCr);
    stage_q.push_back(ChLf);
    stage_q.push_back(8'h42);
    stage_q.push_back(ChCr);
    stage_q.push_back(ChLf);
    stage_q.push_back(ChLf);
    repeat (9) stage_q.push_back(8'($urandom_range(0, 255)));
    stage_q.push_back(8'h80);
    stage_q.push_back(ChCr);
    stage_q.push_back(ChLf);
    launch();

    for (int p = 0; p < 8; p++) begin
      wait_quiet(1'b1);
      repeat (4) @(negedge clk_i);
      write_digit_limit(settings[p]);
      add_chunks(85);
      launch();
      // stall the output so the result buffer fills and blocks the input
      if (p == 1) hold_off_req = 1'b1;
      if (p == 3) begin
        while (body_bytes.size() > 40) @(posedge clk_i);
        sender_hold = 1'b1;
        wait_quiet(1'b0);
        @(posedge clk_i);
        sender_hold = 1'b0;
      end
    end

    wait_quiet(1'b1);
    repeat (4) @(negedge clk_i);
    add_ending();
    launch();
    wait_quiet(1'b1);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("PASS chunked_transfer_decoder_unit");
    end else begin
      $display("FAIL chunked_transfer_decoder_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAIL chunked_transfer_decoder_unit");
    $finish;
  end

endmodule
